@@ rtl/psmc_pkg.sv @@
`timescale 1ns / 1ps

package psmc_pkg;

    localparam int KEY_COUNT = 4;

    // display modes
    localparam logic [1:0] MODE_HOME     = 2'd0;
    localparam logic [1:0] MODE_CONFIRM  = 2'd1;
    localparam logic [1:0] MODE_OVERRIDE = 2'd2;

    // supply selections
    localparam logic [1:0] SUPPLY_OFF     = 2'd0;
    localparam logic [1:0] SUPPLY_GRID    = 2'd1;
    localparam logic [1:0] SUPPLY_SOLAR   = 2'd2;
    localparam logic [1:0] SUPPLY_UNKNOWN = 2'd3;

    // key roles
    localparam logic [1:0] KEY_GRID  = 2'd0;
    localparam logic [1:0] KEY_SOLAR = 2'd1;
    localparam logic [1:0] KEY_BACK  = 2'd2;
    localparam logic [1:0] KEY_MENU  = 2'd3;
    localparam logic [2:0] KEY_NONE  = 3'd4;

    // item kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SOLAR_START = 2'd0;
    localparam logic [1:0] CFG_SOLAR_END   = 2'd1;
    localparam logic [1:0] CFG_OVERRIDE    = 2'd2;
    localparam logic [1:0] CFG_TICKS       = 2'd3;

    localparam logic [7:0]  DUTY_OFF     = 8'd0;
    localparam logic [7:0]  DUTY_BEEP    = 8'd150;
    localparam logic [7:0]  DUTY_WARN    = 8'd200;
    localparam logic [6:0]  SECONDS_TOP  = 7'd59;
    localparam logic [6:0]  SECONDS_INIT = 7'd99;
    localparam logic [10:0] MINUTES_INIT = 11'd99;
    localparam logic [10:0] MINUTES_MAX  = 11'd999;
    localparam logic [10:0] MINUTES_DONE = 11'h7ff;

    typedef struct packed {
        logic [1:0]  mode;
        logic        auto_on;
        logic [1:0]  supply;
        logic [2:0]  prev_key;
        logic [10:0] minutes;   // two's complement, -1 once expired
        logic [6:0]  seconds;
        logic        expired;
        logic [3:0]  phase;     // two's complement buzzer phase
        logic [7:0]  duty;
    } t_state;

endpackage

@@ rtl/psmc_keys.sv @@
`timescale 1ns / 1ps

module psmc_keys import psmc_pkg::*; (
    input  t_state      i_state,
    input  logic [3:0]  i_key_mask,
    input  logic [9:0]  i_override_minutes,
    output t_state      o_state
);

    logic [10:0] w_load_minutes;

    assign w_load_minutes = (i_override_minutes > MINUTES_MAX[9:0])
                          ? MINUTES_MAX : {1'b0, i_override_minutes};

    always_comb begin
        t_state s;
        s = i_state;
        // keys are taken in order, each sees the state left by the one before
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (i_key_mask[k] && (3'(k) != s.prev_key)) begin
                s.prev_key = 3'(k);
                case (2'(k))
                    KEY_GRID, KEY_SOLAR: begin
                        if (s.phase == 4'd0) s.duty = DUTY_BEEP;
                        if (s.phase == 4'd1) begin
                            s.duty  = DUTY_OFF;
                            s.phase = 4'd15;
                        end
                        s.phase = s.phase + 4'd1;
                        if (2'(k) == KEY_GRID) begin
                            if (s.mode == MODE_CONFIRM) begin
                                if (s.auto_on) begin
                                    s.mode    = MODE_OVERRIDE;
                                    s.auto_on = 1'b0;
                                    s.minutes = w_load_minutes;
                                    s.seconds = SECONDS_TOP;
                                    s.expired = 1'b0;
                                end else begin
                                    s.mode    = MODE_HOME;
                                    s.auto_on = 1'b1;
                                end
                            end
                            if (s.mode == MODE_OVERRIDE) s.supply = SUPPLY_GRID;
                        end else begin
                            if (s.mode == MODE_OVERRIDE) s.supply = SUPPLY_SOLAR;
                        end
                    end
                    KEY_BACK: begin
                        if (s.mode == MODE_CONFIRM)
                            s.mode = s.auto_on ? MODE_HOME : MODE_OVERRIDE;
                    end
                    default: begin
                        s.mode = MODE_CONFIRM;
                    end
                endcase
            end
        end
        o_state = s;
    end

endmodule

@@ rtl/power_source_mode_controller_top.sv @@
`timescale 1ns / 1ps

// An input transfer's result is written to the output register as the transfer is accepted.
// Throughput: one item per cycle unless m_axis_tready stalls; output refills as it drains.
// All key and tick work is a single combinational pass from state and input.
// Reset (i_rst_n low at a clock edge) restores all state and the configuration
// registers to their defaults and empties the output register.
module power_source_mode_controller_top import psmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // key_mask[3:0], hour_now[8:4], minute_now[14:9]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // display_mode[1:0], auto_on[2], supply_choice[4:3],
                                       // minutes_left[15:5], seconds_left[22:16],
                                       // timed_out[23], buzzer_duty[31:24]
);

    logic [4:0]  r_solar_start;
    logic [4:0]  r_solar_end;
    logic [9:0]  r_override_minutes;
    logic [3:0]  r_ticks_per_second;

    t_state      r_state;
    t_state      n_state;
    t_state      w_key_state;
    t_state      w_tick_state;
    logic [3:0]  r_tick_count;
    logic [3:0]  n_tick_count;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic        w_accept;
    logic [3:0]  w_key_mask;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute;
    logic [4:0]  w_hours_left;
    logic [10:0] w_window_minutes;
    logic signed [12:0] w_reload;

    assign w_key_mask = s_axis_tdata[3:0];
    assign w_hour     = s_axis_tdata[8:4];
    assign w_minute   = s_axis_tdata[14:9];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solar_start      <= 5'd8;
            r_solar_end        <= 5'd16;
            r_override_minutes <= 10'd60;
            r_ticks_per_second <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SOLAR_START: r_solar_start      <= i_cfg_wdata[4:0];
                CFG_SOLAR_END:   r_solar_end        <= i_cfg_wdata[4:0];
                CFG_OVERRIDE:    r_override_minutes <= i_cfg_wdata;
                CFG_TICKS:       r_ticks_per_second <= i_cfg_wdata[3:0];
                default:         ;
            endcase
        end
    end

    psmc_keys u_keys (
        .i_state            (r_state),
        .i_key_mask         (w_key_mask),
        .i_override_minutes (r_override_minutes),
        .o_state            (w_key_state)
    );

    // minutes left in the solar window: (end - hour) * 60 - minute
    assign w_hours_left     = r_solar_end - w_hour;
    assign w_window_minutes = {w_hours_left, 6'd0} - {4'd0, w_hours_left, 2'd0};
    assign w_reload         = $signed({2'b00, w_window_minutes}) - $signed({7'd0, w_minute});

    always_comb begin
        t_state s;
        logic [3:0] tc;
        s  = r_state;
        tc = r_tick_count;
        case (r_state.mode)
            MODE_HOME: begin
                s.phase = 4'd0;
                s.duty  = DUTY_OFF;
            end
            MODE_CONFIRM: begin
                if (s.phase == 4'd0) s.duty = DUTY_BEEP;
                if (s.phase == 4'd6) s.duty = DUTY_WARN;
                if (s.phase == 4'd7) begin
                    s.duty  = DUTY_OFF;
                    s.phase = 4'd13;
                end
                s.phase = s.phase + 4'd1;
            end
            MODE_OVERRIDE: begin
                s.phase = 4'd0;
                s.duty  = DUTY_OFF;
                if (w_hour >= r_solar_start && w_hour < r_solar_end) begin
                    if (w_reload < -13'sd1)
                        s.minutes = MINUTES_DONE;
                    else if (w_reload > 13'sd999)
                        s.minutes = MINUTES_MAX;
                    else
                        s.minutes = w_reload[10:0];
                end
                tc = tc + 4'd1;
                if (tc >= r_ticks_per_second) begin
                    tc = 4'd0;
                    if (s.seconds == 7'd0) begin
                        s.seconds = SECONDS_TOP;
                        if ($signed(s.minutes) > -11'sd1) s.minutes = s.minutes - 11'd1;
                        if (s.minutes[10]) s.expired = 1'b1;
                    end else begin
                        s.seconds = s.seconds - 7'd1;
                    end
                end
            end
            default: ;
        endcase
        w_tick_state = s;
        n_tick_count = tc;
    end

    assign n_state = (s_axis_tuser == KIND_TICK) ? w_tick_state : w_key_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_HOME;
            r_state.auto_on  <= 1'b1;
            r_state.supply   <= SUPPLY_UNKNOWN;
            r_state.prev_key <= KEY_NONE;
            r_state.minutes  <= MINUTES_INIT;
            r_state.seconds  <= SECONDS_INIT;
            r_state.expired  <= 1'b0;
            r_state.phase    <= 4'd0;
            r_state.duty     <= DUTY_OFF;
            r_tick_count     <= 4'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                if (s_axis_tuser == KIND_TICK) r_tick_count <= n_tick_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {n_state.duty, n_state.expired, n_state.seconds,
                           n_state.minutes, n_state.supply, n_state.auto_on,
                           n_state.mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
